FILE: hw/rtl/ssrb_pkg.sv
// ----------------------------------------------------------------------------
// ssrb_pkg
// Shared types, constants and helpers of the scaled sprite row blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssrb_pkg;

  // sprite geometry
  localparam int SPRITE_DIM   = 16;
  localparam int SPRITE_COUNT = 16;
  localparam int MAX_ROW_CELLS = 64;

  localparam int DIM_W   = $clog2(SPRITE_DIM);
  localparam int SPR_AW  = $clog2(SPRITE_COUNT);
  localparam int CELL_DEPTH = SPRITE_COUNT * SPRITE_DIM * SPRITE_DIM;
  localparam int CELL_AW = $clog2(CELL_DEPTH);
  localparam int CELL_W  = 40;

  // header words
  localparam int HV_W   = 5;
  localparam int HDR_W  = 6 * HV_W;
  localparam int K_W    = $clog2(SPRITE_DIM + 1);
  localparam int OFS_W  = ((HV_W > K_W) ? HV_W : K_W) + 1;
  localparam int R_W    = 14;
  localparam int COLS_W = $clog2(MAX_ROW_CELLS + 1);

  // request codes
  localparam logic [1:0] REQ_CELL = 2'd0;
  localparam logic [1:0] REQ_HDR  = 2'd1;
  localparam logic [1:0] REQ_DRAW = 2'd2;

  // header word selects
  localparam logic [2:0] HDR_PIVOT_X = 3'd0;
  localparam logic [2:0] HDR_PIVOT_Y = 3'd1;
  localparam logic [2:0] HDR_BOX_X   = 3'd2;
  localparam logic [2:0] HDR_BOX_Y   = 3'd3;
  localparam logic [2:0] HDR_BOX_W   = 3'd4;
  localparam logic [2:0] HDR_BOX_H   = 3'd5;

  // configuration register
  localparam logic        REG_OPACITY_MASK = 1'b0;
  localparam logic [31:0] OPACITY_MASK_RST = 32'hFF00_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         sprite_index;
    logic [3:0]         cell_x;
    logic [3:0]         cell_y;
    logic [7:0]         cell_char;
    logic [31:0]        cell_color;
    logic [2:0]         header_sel;
    logic [4:0]         header_value;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic [5:0]         draw_row;
    logic [10:0]        scale_q;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] screen_col;
    logic signed [15:0] screen_row;
    logic [7:0]         out_char;
    logic [31:0]        out_color;
    logic               cell_valid;
    logic               row_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // item accepted
    logic mul1;      // box size products
    logic mul2;      // pivot offset products
    logic sub;       // one restoring step: r -= q, k++
    logic ydone;     // source row known, start the column walk
    logic issue;     // read the cell of column x
    logic advance;   // walk pipeline moves
    logic take;      // opaque cell goes into the pending slot
    logic push;      // pending slot goes out, not last
    logic push_fin;  // final result of the row goes out
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw_ok;
    logic y_out;
    logic r_ge_q;
    logic walk_done;
    logic chk_v;
    logic opaque;
    logic pend_v;
    logic out_free;
  } stat_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [3:0] spr,
                                                   input logic [DIM_W-1:0] y,
                                                   input logic [DIM_W-1:0] x);
    return CELL_AW'((int'(spr) * SPRITE_DIM + int'(y)) * SPRITE_DIM + int'(x));
  endfunction

endpackage

FILE: hw/rtl/scaled_sprite_row_blitter_core.sv
// ----------------------------------------------------------------------------
// scaled_sprite_row_blitter_core
// Nearest-neighbour sprite row scaler with transparency, APB opacity mask.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A cell or header write is done as the item
// is accepted. A draw item is latched, then forms the box products and the
// pivot products, then runs the restoring steps of the source row divide (it
// stops once the source row leaves the sprite), then walks the scaled columns
// (at most 64) with the source column steps between them (at most 16), then
// drains the walk and finishes. The draw time is set by the single read port
// of the cell store and the step unit that replaces the divide by the scale.
// The next item is accepted as soon as the last result sits in the output
// register. Results come out of a one-deep output register; one opaque cell
// is held back so the final one can carry row_last. The stores come up
// undefined after reset, so there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaled_sprite_row_blitter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssrb_pkg::in_item_t  in_item_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssrb_pkg::out_item_t out_item_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  ssrb_pkg::cmd_t  cmd;
  ssrb_pkg::stat_t stat;
  logic [31:0]     opacity_mask_q;
  logic            cfg_wr;

  // opacity mask register, written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready
                  & (paddr[2] == ssrb_pkg::REG_OPACITY_MASK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_mask_q <= ssrb_pkg::OPACITY_MASK_RST;
    end else if (cfg_wr) begin
      opacity_mask_q <= pwdata;
    end
  end

  // reads beyond the register list give zero
  assign prdata = (paddr[2] == ssrb_pkg::REG_OPACITY_MASK) ? opacity_mask_q : 32'h0;

  // sequencer
  ssrb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .req_type_i(in_item_i.req_type),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // stores, arithmetic and output register
  ssrb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_item_i     (in_item_i),
    .opacity_mask_i(opacity_mask_q),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_item_o    (out_item_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );

`ifndef SYNTHESIS
  // a push never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push || cmd.push_fin) |-> stat.out_free)
    else $error("result pushed into a full output register");

  // a draw holds off the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_item_i.req_type == ssrb_pkg::REQ_DRAW))
    |=> in_stall_o)
    else $error("item accepted during a draw");

  // an empty row is a single zeroed last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.cell_valid) |->
    (out_item_o.row_last && (out_item_o.out_color == 32'h0)
     && (out_item_o.screen_col == 16'sh0)))
    else $error("invalid result not clean");

  // cell reads only while columns remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> (!stat.walk_done && !stat.r_ge_q))
    else $error("cell read past the end of the row");
`endif

endmodule

FILE: hw/rtl/ssrb_ram.sv
// ----------------------------------------------------------------------------
// ssrb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ssrb_ctrl.sv
// ----------------------------------------------------------------------------
// ssrb_ctrl
// Sequencer of the row blitter: setup, row divide, column walk, finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            req_type_i,
  output logic                  in_stall_o,
  input  ssrb_pkg::stat_t       stat_i,
  output ssrb_pkg::cmd_t        cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_YDIV = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       stall2;

  // an opaque cell with a full pending slot needs the output register
  assign stall2 = stat_i.chk_v & stat_i.opaque & stat_i.pend_v & ~stat_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (req_type_i == ssrb_pkg::REQ_DRAW) begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = stat_i.draw_ok ? S_YDIV : S_FIN;
      end
      S_YDIV: begin
        if (stat_i.y_out) begin
          state_d = S_FIN;
        end else if (stat_i.r_ge_q) begin
          cmd_o.sub = 1'b1;
        end else begin
          cmd_o.ydone = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        if (!stall2) begin
          cmd_o.advance = 1'b1;
          cmd_o.take    = stat_i.chk_v & stat_i.opaque;
          cmd_o.push    = stat_i.chk_v & stat_i.opaque & stat_i.pend_v;
          if (!stat_i.walk_done) begin
            cmd_o.sub   = stat_i.r_ge_q;
            cmd_o.issue = ~stat_i.r_ge_q;
          end else if (!stat_i.chk_v) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.push_fin = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/ssrb_dp.sv
// ----------------------------------------------------------------------------
// ssrb_dp
// Datapath: sprite stores, scale arithmetic, column walk and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrb_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssrb_pkg::in_item_t  in_item_i,
  input  logic [31:0]         opacity_mask_i,
  input  ssrb_pkg::cmd_t      cmd_i,
  output ssrb_pkg::stat_t     stat_o,
  output ssrb_pkg::out_item_t out_item_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  localparam int HV = ssrb_pkg::HV_W;

  // truncating screen coordinate with saturation
  function automatic logic [15:0] scr(input logic signed [15:0] a,
                                      input logic [5:0]         step,
                                      input logic signed [17:0] dq);
    logic signed [16:0] base;
    logic signed [25:0] num;
    logic signed [17:0] v;
    base = {a[15], a} + $signed({11'b0, step});
    num  = $signed({base[16], base, 8'h00}) + $signed({{8{dq[17]}}, dq});
    v    = num[25:8] + $signed({17'b0, (num[25] && (num[7:0] != 8'h00))});
    if (v > $signed(18'sd32767)) begin
      return 16'h7FFF;
    end else if (v < -$signed(18'sd32768)) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  // header store, no reset
  logic [ssrb_pkg::HDR_W-1:0] hdr_q [ssrb_pkg::SPRITE_COUNT];
  logic [ssrb_pkg::HDR_W-1:0] hdr_rd;

  // latched request
  logic [3:0]         spr_q;
  logic               spr_ok_q;
  logic signed [15:0] ax_q, ay_q;
  logic [5:0]         row_q;
  logic [10:0]        q_q;
  logic [HV-1:0]      px_q, py_q, bx_q, by_q, bw_q, bh_q;

  // setup results
  logic                        draw_ok_q;
  logic [ssrb_pkg::COLS_W-1:0] cols_q;
  logic signed [17:0]          dqx_q, dqy_q;
  logic [15:0]                 bw_prod, bh_prod;
  logic [16:0]                 cols_sum;
  logic signed [5:0]           dx, dy;

  // step unit and walk
  logic [ssrb_pkg::R_W-1:0]    r_q;
  logic [ssrb_pkg::K_W-1:0]    k_q;
  logic [ssrb_pkg::COLS_W-1:0] x_q;
  logic [ssrb_pkg::DIM_W-1:0]  sy_q;
  logic [15:0]                 srow_q;
  logic [5:0]                  col2_q;
  logic                        chk_v_q;
  logic [ssrb_pkg::OFS_W-1:0]  sx_sum, sy_sum;

  // pending slot and output register
  logic        pend_v_q;
  logic [15:0] pend_col_q, pend_row_q;
  logic [7:0]  pend_char_q;
  logic [31:0] pend_color_q;
  logic        out_valid_q;
  ssrb_pkg::out_item_t out_q;

  // cell store
  logic                          cell_we;
  logic [ssrb_pkg::CELL_AW-1:0]  cell_waddr, cell_raddr;
  logic [ssrb_pkg::CELL_W-1:0]   cell_rdata;
  logic                          out_free;

  assign hdr_rd = hdr_q[ssrb_pkg::SPR_AW'(in_item_i.sprite_index)];

  assign cell_we = cmd_i.load && (in_item_i.req_type == ssrb_pkg::REQ_CELL)
                   && (int'(in_item_i.sprite_index) < ssrb_pkg::SPRITE_COUNT)
                   && (int'(in_item_i.cell_x) < ssrb_pkg::SPRITE_DIM)
                   && (int'(in_item_i.cell_y) < ssrb_pkg::SPRITE_DIM);
  assign cell_waddr = ssrb_pkg::cell_addr(in_item_i.sprite_index,
                                          ssrb_pkg::DIM_W'(in_item_i.cell_y),
                                          ssrb_pkg::DIM_W'(in_item_i.cell_x));
  assign sx_sum = ssrb_pkg::OFS_W'(bx_q) + ssrb_pkg::OFS_W'(k_q);
  assign sy_sum = ssrb_pkg::OFS_W'(by_q) + ssrb_pkg::OFS_W'(k_q);
  assign cell_raddr = ssrb_pkg::cell_addr(spr_q, sy_q, ssrb_pkg::DIM_W'(sx_sum));

  ssrb_ram #(
    .WIDTH(ssrb_pkg::CELL_W),
    .DEPTH(ssrb_pkg::CELL_DEPTH)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(cell_waddr),
    .wdata_i({in_item_i.cell_char, in_item_i.cell_color}),
    .re_i   (cmd_i.issue),
    .raddr_i(cell_raddr),
    .rdata_o(cell_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (in_item_i.req_type == ssrb_pkg::REQ_HDR)
        && (int'(in_item_i.sprite_index) < ssrb_pkg::SPRITE_COUNT)
        && (in_item_i.header_sel <= ssrb_pkg::HDR_BOX_H)) begin
      hdr_q[ssrb_pkg::SPR_AW'(in_item_i.sprite_index)][HV*in_item_i.header_sel +: HV]
        <= in_item_i.header_value;
    end
  end

  // setup arithmetic
  assign bw_prod  = 16'(bw_q * q_q);
  assign bh_prod  = 16'(bh_q * q_q);
  assign cols_sum = 17'(bw_prod) + 17'd255;
  assign dx = $signed({1'b0, bx_q}) - $signed({1'b0, px_q});
  assign dy = $signed({1'b0, by_q}) - $signed({1'b0, py_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      spr_q    <= in_item_i.sprite_index;
      spr_ok_q <= (int'(in_item_i.sprite_index) < ssrb_pkg::SPRITE_COUNT);
      ax_q     <= in_item_i.anchor_x;
      ay_q     <= in_item_i.anchor_y;
      row_q    <= in_item_i.draw_row;
      q_q      <= in_item_i.scale_q;
      px_q     <= hdr_rd[HV*ssrb_pkg::HDR_PIVOT_X +: HV];
      py_q     <= hdr_rd[HV*ssrb_pkg::HDR_PIVOT_Y +: HV];
      bx_q     <= hdr_rd[HV*ssrb_pkg::HDR_BOX_X +: HV];
      by_q     <= hdr_rd[HV*ssrb_pkg::HDR_BOX_Y +: HV];
      bw_q     <= hdr_rd[HV*ssrb_pkg::HDR_BOX_W +: HV];
      bh_q     <= hdr_rd[HV*ssrb_pkg::HDR_BOX_H +: HV];
    end
    if (cmd_i.mul1) begin
      draw_ok_q <= spr_ok_q && (q_q != 11'd0) && (16'({row_q, 8'h00}) < bh_prod);
      if (cols_sum[16:8] > 9'(ssrb_pkg::MAX_ROW_CELLS)) begin
        cols_q <= ssrb_pkg::COLS_W'(ssrb_pkg::MAX_ROW_CELLS);
      end else begin
        cols_q <= ssrb_pkg::COLS_W'(cols_sum[16:8]);
      end
      r_q <= ssrb_pkg::R_W'({row_q, 8'h00});
      k_q <= '0;
    end
    if (cmd_i.mul2) begin
      dqx_q <= 18'(dx * $signed({1'b0, q_q}));
      dqy_q <= 18'(dy * $signed({1'b0, q_q}));
    end
    if (cmd_i.sub) begin
      r_q <= r_q - ssrb_pkg::R_W'(q_q);
      k_q <= k_q + ssrb_pkg::K_W'(1);
    end
    if (cmd_i.ydone) begin
      sy_q   <= ssrb_pkg::DIM_W'(sy_sum);
      srow_q <= scr(ay_q, row_q, dqy_q);
      x_q    <= '0;
      r_q    <= '0;
      k_q    <= '0;
    end
    if (cmd_i.issue) begin
      col2_q <= 6'(x_q);
      x_q    <= x_q + ssrb_pkg::COLS_W'(1);
      r_q    <= r_q + ssrb_pkg::R_W'(256);
    end
    if (cmd_i.take) begin
      pend_col_q   <= scr(ax_q, col2_q, dqx_q);
      pend_row_q   <= srow_q;
      pend_char_q  <= cell_rdata[39:32];
      pend_color_q <= cell_rdata[31:0];
    end
    if (cmd_i.push) begin
      out_q <= '{screen_col: pend_col_q, screen_row: pend_row_q, out_char: pend_char_q,
                 out_color: pend_color_q, cell_valid: 1'b1, row_last: 1'b0};
    end else if (cmd_i.push_fin) begin
      if (pend_v_q) begin
        out_q <= '{screen_col: pend_col_q, screen_row: pend_row_q, out_char: pend_char_q,
                   out_color: pend_color_q, cell_valid: 1'b1, row_last: 1'b1};
      end else begin
        out_q <= '{screen_col: 16'h0000, screen_row: 16'h0000, out_char: 8'h00,
                   out_color: 32'h0, cell_valid: 1'b0, row_last: 1'b1};
      end
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_v_q     <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.advance) begin
        chk_v_q <= cmd_i.issue;
      end
      if (cmd_i.load || cmd_i.push_fin) begin
        pend_v_q <= 1'b0;
      end else if (cmd_i.take) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.push || cmd_i.push_fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.draw_ok   = draw_ok_q;
  assign stat_o.y_out     = (int'(sy_sum) >= ssrb_pkg::SPRITE_DIM);
  assign stat_o.r_ge_q    = (r_q >= ssrb_pkg::R_W'(q_q));
  assign stat_o.walk_done = (x_q >= cols_q) || (int'(sx_sum) >= ssrb_pkg::SPRITE_DIM);
  assign stat_o.chk_v     = chk_v_q;
  assign stat_o.opaque    = ((cell_rdata[31:0] & opacity_mask_i) != 32'h0);
  assign stat_o.pend_v    = pend_v_q;
  assign stat_o.out_free  = out_free;

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule
